// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape block.
// No dependencies; used by the front end, the queue, the serializer and the top level.
package jsu_pkg;

    localparam int GRP_MAX     = 4;
    localparam int QUEUE_DEPTH = 2;

    // Decoded bytes of one transaction: up to four bytes, a byte count, a close flag.
    typedef struct packed {
        logic [GRP_MAX-1:0][7:0] b;
        logic [2:0]              n;
        logic                    fin;
    } t_grp;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/jsu_in_if.sv =====
// Input channel of the JSON string unescape block: valid/ready plus kind and byte.
// Depends on nothing.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] in_byte;

    modport source (output valid, kind, in_byte, input ready);
    modport sink   (input valid, kind, in_byte, output ready);
endinterface

// ===== rtl/jsu_out_if.sv =====
// Output channel of the JSON string unescape block: valid/ready plus decoded byte flags.
// Depends on nothing.
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;
    logic       finished;

    modport source (output valid, out_byte, has_byte, last, finished, input ready);
    modport sink   (input valid, out_byte, has_byte, last, finished, output ready);
endinterface

// ===== rtl/jsu_front.sv =====
// Front end: escape/hex/surrogate state machine, turns one input byte into a byte group.
// Depends on jsu_pkg.
module jsu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_kind,
    input  logic [7:0]        i_byte,
    output jsu_pkg::t_grp     o_grp
);
    localparam logic [2:0] M_AWAIT      = 3'd0;
    localparam logic [2:0] M_BODY       = 3'd1;
    localparam logic [2:0] M_ESC        = 3'd2;
    localparam logic [2:0] M_HEX        = 3'd3;
    localparam logic [2:0] M_AFTER_HIGH = 3'd4;
    localparam logic [2:0] M_HIGH_BS    = 3'd5;
    localparam logic [2:0] M_LOW_HEX    = 3'd6;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [15:0] SURR_HI_LO = 16'hD800;
    localparam logic [15:0] SURR_LO_LO = 16'hDC00;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
        return v;
    endfunction

    function automatic logic [7:0] esc_char(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h6E:   r = 8'h0A;
            8'h74:   r = 8'h09;
            8'h72:   r = 8'h0D;
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic jsu_pkg::t_grp put_byte(input jsu_pkg::t_grp g, input logic [7:0] b);
        jsu_pkg::t_grp r;
        r = g;
        if (r.n < 3'(jsu_pkg::GRP_MAX)) begin
            r.b[r.n[1:0]] = b;
            r.n = r.n + 3'd1;
        end
        return r;
    endfunction

    function automatic jsu_pkg::t_grp utf8_enc(input logic [31:0] cp);
        jsu_pkg::t_grp g;
        g = '0;
        if (cp < 32'h80) begin
            g.b[0] = cp[7:0];
            g.n = 3'd1;
        end else if (cp < 32'h800) begin
            g.b[0] = 8'hC0 | cp[13:6];
            g.b[1] = 8'h80 | {2'b00, cp[5:0]};
            g.n = 3'd2;
        end else if (cp < 32'h10000) begin
            g.b[0] = 8'hE0 | cp[19:12];
            g.b[1] = 8'h80 | {2'b00, cp[11:6]};
            g.b[2] = 8'h80 | {2'b00, cp[5:0]};
            g.n = 3'd3;
        end else begin
            g.b[0] = 8'hF0 | cp[25:18];
            g.b[1] = 8'h80 | {2'b00, cp[17:12]};
            g.b[2] = 8'h80 | {2'b00, cp[11:6]};
            g.b[3] = 8'h80 | {2'b00, cp[5:0]};
            g.n = 3'd4;
        end
        return g;
    endfunction

    logic [2:0]    r_mode, n_mode;
    logic [15:0]   r_acc, n_acc;
    logic [2:0]    r_cnt, n_cnt;
    logic [15:0]   r_hh, n_hh;

    logic [15:0]   acc_sh;
    logic [15:0]   acc_v;
    logic [2:0]    cnt_inc;
    logic [31:0]   comb_cp;
    logic [31:0]   main_cp;
    jsu_pkg::t_grp enc_main;
    jsu_pkg::t_grp enc_hh;
    jsu_pkg::t_grp g;
    logic          do_body;
    logic          do_esc;

    assign acc_sh  = {r_acc[11:0], hex_val(i_byte)};
    assign acc_v   = i_kind ? r_acc : acc_sh;
    assign cnt_inc = r_cnt + 3'd1;
    assign comb_cp = 32'h10000 + (({16'b0, r_hh} - {16'b0, SURR_HI_LO}) << 10)
                     + ({16'b0, acc_v} - {16'b0, SURR_LO_LO});
    assign main_cp = (r_mode == M_LOW_HEX) ? comb_cp : {16'b0, acc_v};
    assign enc_main = utf8_enc(main_cp);
    assign enc_hh   = utf8_enc({16'b0, r_hh});

    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_hh    = r_hh;
        g       = '0;
        do_body = 1'b0;
        do_esc  = 1'b0;
        if (i_kind) begin
            unique case (r_mode)
                M_ESC:        g = put_byte(g, CH_BSL);
                M_HEX:        g = enc_main;
                M_AFTER_HIGH: g = enc_hh;
                M_HIGH_BS:    g = put_byte(enc_hh, CH_BSL);
                M_LOW_HEX:    g = enc_main;
                default:      g = '0;
            endcase
            g.fin  = 1'b1;
            n_mode = M_AWAIT;
            n_acc  = '0;
            n_cnt  = '0;
        end else begin
            unique case (r_mode)
                M_BODY: do_body = 1'b1;
                M_ESC:  do_esc  = 1'b1;
                M_HEX, M_LOW_HEX: begin
                    n_acc = acc_sh;
                    n_cnt = cnt_inc;
                    if (cnt_inc[2]) begin
                        n_cnt = '0;
                        n_acc = '0;
                        if (r_mode == M_LOW_HEX) begin
                            g      = enc_main;
                            n_mode = M_BODY;
                        end else if (acc_sh >= SURR_HI_LO && acc_sh < SURR_LO_LO) begin
                            n_hh   = acc_sh;
                            n_mode = M_AFTER_HIGH;
                        end else begin
                            g      = enc_main;
                            n_mode = M_BODY;
                        end
                    end
                end
                M_AFTER_HIGH: begin
                    if (i_byte == CH_BSL) begin
                        n_mode = M_HIGH_BS;
                    end else begin
                        g       = enc_hh;
                        do_body = 1'b1;
                    end
                end
                M_HIGH_BS: begin
                    if (i_byte == CH_U) begin
                        n_mode = M_LOW_HEX;
                        n_acc  = '0;
                        n_cnt  = '0;
                    end else begin
                        g      = enc_hh;
                        do_esc = 1'b1;
                    end
                end
                default: begin
                    n_mode = M_BODY;
                    n_acc  = '0;
                    n_cnt  = '0;
                end
            endcase
            if (do_body) begin
                n_mode = M_BODY;
                if (i_byte == CH_QUOTE) begin
                    n_mode = M_AWAIT;
                    g.fin  = 1'b1;
                end else if (i_byte == CH_BSL) begin
                    n_mode = M_ESC;
                end else begin
                    g = put_byte(g, i_byte);
                end
            end
            if (do_esc) begin
                n_mode = M_BODY;
                if (i_byte == CH_U) begin
                    n_mode = M_HEX;
                    n_acc  = '0;
                    n_cnt  = '0;
                end else begin
                    g = put_byte(g, esc_char(i_byte));
                end
            end
        end
    end

    assign o_grp = g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_AWAIT;
            r_acc  <= '0;
            r_cnt  <= '0;
            r_hh   <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_hh   <= n_hh;
        end
    end
endmodule

// ===== rtl/jsu_queue.sv =====
// Small register FIFO of byte groups between the front end and the output serializer.
// Depends on jsu_pkg.
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  jsu_pkg::t_grp     i_grp,
    input  logic              i_pop,
    output jsu_pkg::t_grp     o_head,
    output jsu_pkg::t_q_stat  o_stat
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    jsu_pkg::t_grp    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) n_wp = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
        if (i_pop)  n_rp = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
        if (i_push && !i_pop) n_cnt = r_cnt + 1'b1;
        else if (!i_push && i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_grp;
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CNT_FULL);
    assign o_stat.empty = (r_cnt == '0);
endmodule

// ===== rtl/jsu_back.sv =====
// Back end: walks the head byte group and emits one result per output transaction.
// Depends on jsu_pkg.
module jsu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jsu_pkg::t_grp     i_head,
    input  logic              i_avail,
    input  logic              i_take,
    output logic              o_pop,
    output logic [7:0]        o_byte,
    output logic              o_has_byte,
    output logic              o_last,
    output logic              o_finished
);
    logic [1:0] r_idx;
    logic [1:0] last_idx;

    assign last_idx   = (i_head.n == 3'd0) ? 2'd0 : 2'(i_head.n - 3'd1);
    assign o_has_byte = (i_head.n != 3'd0);
    assign o_byte     = o_has_byte ? i_head.b[r_idx] : 8'h00;
    assign o_last     = (r_idx == last_idx);
    assign o_finished = i_head.fin;
    assign o_pop      = i_avail && i_take && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_avail && i_take) begin
            r_idx <= o_last ? 2'd0 : r_idx + 2'd1;
        end
    end
endmodule

// ===== rtl/json_string_unescape_utf8_top.sv =====
// Top level of the JSON string unescape to UTF-8 block: front end, queue, serializer.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_front, jsu_queue, jsu_back.
//
//   channel  | modport | payload                               | moves on
//   i_src    | sink    | kind, in_byte                         | valid && ready
//   o_res    | source  | out_byte, has_byte, last, finished    | valid && ready
//
// An input transaction is decoded in the cycle it is accepted and its 0 to 4 result
// bytes are queued; the serializer sends one result per cycle from the queue head
// while the output is ready. Input rate is one per cycle while each item yields
// one result; longer groups hold the head and the input stalls when the queue fills.
// Synchronous active-low reset empties the queue and returns to await-opening-quote.
module json_string_unescape_utf8_top #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsu_in_if.sink     i_src,
    jsu_out_if.source  o_res
);
    jsu_pkg::t_grp    grp;
    jsu_pkg::t_grp    head;
    jsu_pkg::t_q_stat q_stat;
    logic             accept;
    logic             pop;

    assign i_src.ready = i_rst_n && !q_stat.full;
    assign accept      = i_src.valid && i_src.ready;
    assign o_res.valid = i_rst_n && !q_stat.empty;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_kind   (i_src.kind),
        .i_byte   (i_src.in_byte),
        .o_grp    (grp)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_grp   (grp),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    jsu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_avail    (o_res.valid),
        .i_take     (o_res.ready),
        .o_pop      (pop),
        .o_byte     (o_res.out_byte),
        .o_has_byte (o_res.has_byte),
        .o_last     (o_res.last),
        .o_finished (o_res.finished)
    );
endmodule

// ===== rtl/jsu_checker.sv =====
// Port-level checks of the JSON string unescape block, bound to its top level.
// Depends on json_string_unescape_utf8_top and jsu_out_if.
module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [7:0] i_out_byte,
    input logic       i_has_byte,
    input logic       i_last,
    input logic       i_finished
);
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid && $stable(i_out_byte)
            && $stable(i_last) && $stable(i_finished))
        else $error("result dropped or changed while stalled");

    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_has_byte) |-> (i_last && i_out_byte == 8'h00))
        else $error("no-byte result not a single zero result");

    a_group_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_ready && !i_last) |=>
            (i_res_valid && i_has_byte && i_finished == $past(i_finished)))
        else $error("byte group broken or close flag changed inside group");

    a_lead_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_ready && !i_last && i_out_byte[7:6] == 2'b10) |=>
            (i_out_byte[7:6] == 2'b10 || i_last))
        else $error("continuation byte followed by non-continuation before group end");
endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_out_byte  (o_res.out_byte),
    .i_has_byte  (o_res.has_byte),
    .i_last      (o_res.last),
    .i_finished  (o_res.finished)
);

// ===== test/json_string_unescape_utf8_top_tb.sv =====
// Testbench for json_string_unescape_utf8_top: drives directed and random JSON string bytes,
// predicts the UTF-8 result stream per transaction and checks it field by field.
// Depends on jsu_in_if, jsu_out_if and the RTL of the block.
module json_string_unescape_utf8_top_tb;

    typedef enum logic [2:0] {
        ST_AWAIT, ST_BODY, ST_ESC, ST_HEX, ST_AFTER_HIGH, ST_HIGH_BS, ST_LOW_HEX
    } t_dec_state;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_src_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
        logic       finished;
    } t_res;

    localparam logic       KIND_BYTE  = 1'b0;
    localparam logic       KIND_FLUSH = 1'b1;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] ESC_LF     = 8'h6E;
    localparam logic [7:0] ESC_TAB    = 8'h74;
    localparam logic [7:0] ESC_CR     = 8'h72;
    localparam logic [7:0] ESC_BS     = 8'h62;
    localparam logic [7:0] ESC_FF     = 8'h66;
    localparam logic [7:0] CTRL_LF    = 8'h0A;
    localparam logic [7:0] CTRL_TAB   = 8'h09;
    localparam logic [7:0] CTRL_CR    = 8'h0D;
    localparam logic [7:0] CTRL_BS    = 8'h08;
    localparam logic [7:0] CTRL_FF    = 8'h0C;
    localparam int         RX_OPEN    = 0;
    localparam int         RX_MASK    = 1;
    localparam int         RX_COIN    = 2;
    localparam int         TOTAL_ITEMS  = 180;
    localparam int         TAIL_CYCLES  = 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    jsu_in_if  src_if ();
    jsu_out_if res_if ();

    json_string_unescape_utf8_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_if),
        .o_res   (res_if)
    );

    always #6 i_clk = ~i_clk;

    // decoder state mirrored from the block
    t_dec_state  dec_mode  = ST_AWAIT;
    logic [31:0] cp_accum  = '0;
    logic [2:0]  digit_cnt = '0;
    logic [15:0] hi_surr   = '0;
    logic [7:0]  utf8_bytes[$];

    t_res        expected_res[$];
    t_src_item   src_items[$];
    logic [7:0]  frag[$];
    int          items_total = 0;
    int          items_taken = 0;
    int          fail_cnt = 0;

    function automatic void emit_byte(input logic [7:0] b);
        utf8_bytes.insert(utf8_bytes.size(), b);
    endfunction

    function automatic void emit_utf8(input logic [31:0] cp);
        if (cp < 32'h80) begin
            emit_byte(cp[7:0]);
        end else if (cp < 32'h800) begin
            emit_byte(8'hC0 | cp[13:6]);
            emit_byte(8'h80 | {2'b00, cp[5:0]});
        end else if (cp < 32'h10000) begin
            emit_byte(8'hE0 | cp[19:12]);
            emit_byte(8'h80 | {2'b00, cp[11:6]});
            emit_byte(8'h80 | {2'b00, cp[5:0]});
        end else begin
            emit_byte(8'hF0 | cp[25:18]);
            emit_byte(8'h80 | {2'b00, cp[17:12]});
            emit_byte(8'h80 | {2'b00, cp[11:6]});
            emit_byte(8'h80 | {2'b00, cp[5:0]});
        end
    endfunction

    function automatic logic [31:0] pair_code();
        return 32'h10000 + (({16'h0, hi_surr} - 32'hD800) << 10) + (cp_accum - 32'hDC00);
    endfunction

    function automatic logic take_body(input logic [7:0] ch);
        if (ch == CH_QUOTE) begin
            dec_mode = ST_AWAIT;
            return 1'b1;
        end
        if (ch == CH_BSLASH) dec_mode = ST_ESC;
        else emit_byte(ch);
        return 1'b0;
    endfunction

    function automatic void take_escape(input logic [7:0] ch);
        dec_mode = ST_BODY;
        case (ch)
            ESC_LF:  emit_byte(CTRL_LF);
            ESC_TAB: emit_byte(CTRL_TAB);
            ESC_CR:  emit_byte(CTRL_CR);
            ESC_BS:  emit_byte(CTRL_BS);
            ESC_FF:  emit_byte(CTRL_FF);
            CH_U: begin
                dec_mode  = ST_HEX;
                cp_accum  = '0;
                digit_cnt = '0;
            end
            default: emit_byte(ch);
        endcase
    endfunction

    function automatic void decode_item(input logic kind, input logic [7:0] ch);
        logic        closes;
        logic [31:0] nib;
        t_res        r;
        closes = 1'b0;
        utf8_bytes.delete();
        if (kind == KIND_FLUSH) begin
            case (dec_mode)
                ST_ESC:        emit_byte(CH_BSLASH);
                ST_HEX:        emit_utf8(cp_accum);
                ST_AFTER_HIGH: emit_utf8({16'h0, hi_surr});
                ST_HIGH_BS: begin
                    emit_utf8({16'h0, hi_surr});
                    emit_byte(CH_BSLASH);
                end
                ST_LOW_HEX:    emit_utf8(pair_code());
                default: ;
            endcase
            closes    = 1'b1;
            dec_mode  = ST_AWAIT;
            cp_accum  = '0;
            digit_cnt = '0;
        end else begin
            case (dec_mode)
                ST_BODY: closes = take_body(ch);
                ST_ESC:  take_escape(ch);
                ST_HEX, ST_LOW_HEX: begin
                    if (ch >= "0" && ch <= "9") nib = {24'h0, 8'(ch - "0")};
                    else if (ch >= "a" && ch <= "f") nib = {24'h0, 8'(ch - "a" + 8'd10)};
                    else if (ch >= "A" && ch <= "F") nib = {24'h0, 8'(ch - "A" + 8'd10)};
                    else nib = '0;
                    cp_accum  = (cp_accum << 4) | nib;
                    digit_cnt = digit_cnt + 3'd1;
                    if (digit_cnt >= 3'd4) begin
                        digit_cnt = '0;
                        if (dec_mode == ST_LOW_HEX) begin
                            emit_utf8(pair_code());
                            dec_mode = ST_BODY;
                        end else if (cp_accum >= 32'hD800 && cp_accum < 32'hDC00) begin
                            hi_surr  = cp_accum[15:0];
                            dec_mode = ST_AFTER_HIGH;
                        end else begin
                            emit_utf8(cp_accum);
                            dec_mode = ST_BODY;
                        end
                        cp_accum = '0;
                    end
                end
                ST_AFTER_HIGH: begin
                    if (ch == CH_BSLASH) begin
                        dec_mode = ST_HIGH_BS;
                    end else begin
                        emit_utf8({16'h0, hi_surr});
                        dec_mode = ST_BODY;
                        closes   = take_body(ch);
                    end
                end
                ST_HIGH_BS: begin
                    if (ch == CH_U) begin
                        dec_mode  = ST_LOW_HEX;
                        cp_accum  = '0;
                        digit_cnt = '0;
                    end else begin
                        emit_utf8({16'h0, hi_surr});
                        take_escape(ch);
                    end
                end
                default: begin
                    dec_mode  = ST_BODY;
                    cp_accum  = '0;
                    digit_cnt = '0;
                end
            endcase
        end
        if (utf8_bytes.size() == 0) begin
            r = '{out_byte: 8'h00, has_byte: 1'b0, last: 1'b1, finished: closes};
            expected_res.insert(expected_res.size(), r);
        end else begin
            foreach (utf8_bytes[i]) begin
                r.out_byte = utf8_bytes[i];
                r.has_byte = 1'b1;
                r.last     = (i == utf8_bytes.size() - 1);
                r.finished = closes;
                expected_res.insert(expected_res.size(), r);
            end
        end
    endfunction

    // stimulus building
    function automatic void put_byte(input logic [7:0] b);
        frag.insert(frag.size(), b);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void put_hex(input logic [15:0] v);
        logic [3:0] nib;
        for (int i = 3; i >= 0; i--) begin
            nib = v[i*4 +: 4];
            if ($urandom_range(0, 11) == 0) put_byte(8'($urandom_range(0, 255)));
            else if (nib < 4'd10) put_byte(8'("0" + nib));
            else if ($urandom_range(0, 1)) put_byte(8'("A" + nib - 8'd10));
            else put_byte(8'("a" + nib - 8'd10));
        end
    endfunction

    function automatic void send_frag(input int keep);
        for (int i = 0; i < keep; i++)
            src_items.insert(src_items.size(), '{kind: KIND_BYTE, data: frag[i]});
        frag.delete();
    endfunction

    function automatic void send_flush();
        src_items.insert(src_items.size(),
                         '{kind: KIND_FLUSH, data: 8'($urandom_range(0, 255))});
    endfunction

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(16'h0000, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hFFFF));
            3: return 16'($urandom_range(16'hD800, 16'hDBFF));
            default: return 16'($urandom_range(16'hDC00, 16'hDFFF));
        endcase
    endfunction

    function automatic void put_escape_char();
        case ($urandom_range(0, 8))
            0: put_byte(ESC_LF);
            1: put_byte(ESC_TAB);
            2: put_byte(ESC_CR);
            3: put_byte(ESC_BS);
            4: put_byte(ESC_FF);
            5: put_byte(CH_QUOTE);
            6: put_byte(CH_BSLASH);
            7: put_byte(CH_SLASH);
            default: put_byte(8'($urandom_range(0, 255)));
        endcase
    endfunction

    initial begin
        int         n_elem;
        logic       cut;
        logic [7:0] b;

        put_byte(CH_QUOTE);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_text("\\n\\uD83d\\udc00\\ugFff\"");
        send_frag(frag.size());
        put_text("\"\\");
        send_frag(frag.size());
        send_flush();

        while (src_items.size() < TOTAL_ITEMS) begin
            put_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_QUOTE);
            send_frag(frag.size());
            n_elem = $urandom_range(0, 7);
            cut = 1'b0;
            for (int e = 0; e < n_elem && !cut; e++) begin
                case ($urandom_range(0, 6))
                    0, 1: begin
                        b = 8'($urandom_range(0, 255));
                        if ((b == CH_QUOTE || b == CH_BSLASH) && $urandom_range(0, 3) != 0)
                            b = 8'($urandom_range(8'h20, 8'h21));
                        put_byte(b);
                    end
                    2: begin
                        put_byte(CH_BSLASH);
                        put_escape_char();
                    end
                    3, 4: begin
                        put_byte(CH_BSLASH);
                        put_byte(CH_U);
                        put_hex(pick_code());
                    end
                    5: begin
                        put_byte(CH_BSLASH);
                        put_byte(CH_U);
                        put_hex(16'($urandom_range(16'hD800, 16'hDBFF)));
                        put_byte(CH_BSLASH);
                        put_byte(CH_U);
                        put_hex(($urandom_range(0, 5) == 0)
                                ? 16'($urandom_range(0, 16'hFFFF))
                                : 16'($urandom_range(16'hDC00, 16'hDFFF)));
                    end
                    default: begin
                        put_byte(CH_BSLASH);
                        put_byte(CH_U);
                        put_hex(16'($urandom_range(16'hD800, 16'hDBFF)));
                        case ($urandom_range(0, 2))
                            0: put_byte(8'($urandom_range(0, 255)));
                            1: begin
                                put_byte(CH_BSLASH);
                                put_escape_char();
                            end
                            default: put_byte(CH_QUOTE);
                        endcase
                    end
                endcase
                if (frag.size() > 1 && $urandom_range(0, 7) == 0) begin
                    send_frag(int'($urandom_range(1, frag.size() - 1)));
                    send_flush();
                    cut = 1'b1;
                end else begin
                    send_frag(frag.size());
                end
            end
            if (!cut) begin
                if ($urandom_range(0, 9) < 7) begin
                    put_byte(CH_QUOTE);
                    send_frag(1);
                end else begin
                    send_flush();
                end
            end
            if ($urandom_range(0, 7) == 0) send_flush();
        end
        items_total = src_items.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_taken < items_total) @(posedge i_clk);
        while (expected_res.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && expected_res.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    // sender: bursts with gaps
    int        burst_left = 1;
    int        gap_left = 0;
    t_src_item next_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_if.valid   <= 1'b0;
            src_if.kind    <= KIND_BYTE;
            src_if.in_byte <= 8'h00;
        end else if (!src_if.valid || src_if.ready) begin
            if (gap_left != 0 || src_items.size() == 0) begin
                if (gap_left != 0) gap_left--;
                src_if.valid <= 1'b0;
            end else begin
                next_item = src_items.pop_front();
                src_if.valid   <= 1'b1;
                src_if.kind    <= next_item.kind;
                src_if.in_byte <= next_item.data;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver: stall styles chosen anew for each random span
    int         stall_style = RX_OPEN;
    int         span_left = 0;
    logic [7:0] stall_mask = 8'hFF;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (span_left == 0) begin
                stall_style = $urandom_range(RX_OPEN, RX_COIN);
                stall_mask  = 8'($urandom_range(1, 255));
                span_left   = $urandom_range(8, 48);
            end
            span_left--;
            stall_mask = {stall_mask[6:0], stall_mask[7]};
            case (stall_style)
                RX_OPEN: res_if.ready <= 1'b1;
                RX_MASK: res_if.ready <= stall_mask[0];
                default: res_if.ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // monitor: predict on input transaction, check on output transaction
    t_res want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (src_if.valid && src_if.ready) begin
                decode_item(src_if.kind, src_if.in_byte);
                items_taken++;
            end
            if (res_if.valid && res_if.ready) begin
                if (expected_res.size() == 0) begin
                    $error("result with nothing pending: out_byte %0h", res_if.out_byte);
                    fail_cnt++;
                end else begin
                    want = expected_res.pop_front();
                    if (res_if.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte, res_if.out_byte);
                        fail_cnt++;
                    end
                    if (res_if.has_byte !== want.has_byte) begin
                        $error("has_byte: expected %0b, got %0b", want.has_byte, res_if.has_byte);
                        fail_cnt++;
                    end
                    if (res_if.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, res_if.last);
                        fail_cnt++;
                    end
                    if (res_if.finished !== want.finished) begin
                        $error("finished: expected %0b, got %0b", want.finished, res_if.finished);
                        fail_cnt++;
                    end
                end
            end
        end
    end

endmodule
